@@ src/lpse_pkg.sv @@
// Package for the LSB pixel steganography embedder.
// Holds shared widths, register indexes and the channel mask helpers.
// No dependencies.
package lpse_pkg;

   localparam int CHAN_BITS      = 8;
   localparam int CHAR_BITS      = 8;
   localparam int BPC_BITS       = 2;
   localparam int MSG_LEN_BITS   = 24;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int WORD_BITS      = 32;
   localparam int REM_BITS       = 6;
   localparam int COUNT_BITS     = 25;
   localparam int FIELD_BITS     = 3;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BITS_PER_CHANNEL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MESSAGE_LENGTH   = 2'd1;

   localparam logic [BPC_BITS-1:0]  BPC_RESET = 2'd1;
   localparam logic [REM_BITS-1:0]  REM_FULL  = 6'd32;

   localparam logic [CHAN_BITS-1:0] MASK_ONE_BIT    = 8'hFE;
   localparam logic [CHAN_BITS-1:0] MASK_TWO_BITS   = 8'hFC;
   localparam logic [CHAN_BITS-1:0] MASK_THREE_BITS = 8'hF8;

   typedef logic [CHAN_BITS-1:0] chan_type;
   typedef logic [REM_BITS-1:0]  rem_type;

   // mask that clears the low n bits of a channel (n is 1..3)
   function automatic chan_type clear_mask_f(input logic [BPC_BITS-1:0] n);
      chan_type m;
      unique case (n)
         2'd1:    m = MASK_ONE_BIT;
         2'd2:    m = MASK_TWO_BITS;
         default: m = MASK_THREE_BITS;
      endcase
      return m;
   endfunction

   // low n bits set (n is 1..3)
   function automatic logic [FIELD_BITS-1:0] low_mask_f(input logic [BPC_BITS-1:0] n);
      logic [FIELD_BITS-1:0] m;
      unique case (n)
         2'd1:    m = 3'b001;
         2'd2:    m = 3'b011;
         default: m = 3'b111;
      endcase
      return m;
   endfunction

endpackage

@@ src/lpse_channel_insert.sv @@
// One colour channel of the embedder: pick the next field of the word and
// merge it into the channel's low bits. Depends on lpse_pkg.
module lpse_channel_insert (
   input  logic [lpse_pkg::CHAN_BITS-1:0] chan_in,
   input  logic [lpse_pkg::WORD_BITS-1:0] word,
   input  logic [lpse_pkg::REM_BITS-1:0]  rem_in,
   input  logic [lpse_pkg::BPC_BITS-1:0]  bits,
   output logic [lpse_pkg::CHAN_BITS-1:0] chan_out,
   output logic [lpse_pkg::REM_BITS-1:0]  rem_out
);
   import lpse_pkg::*;

   logic [WORD_BITS+FIELD_BITS-1:0] word_ext;
   logic [WORD_BITS+FIELD_BITS-1:0] shifted;
   logic [REM_BITS-1:0]             shift_amt;
   logic [REM_BITS-1:0]             bits_wide;
   logic [FIELD_BITS-1:0]           field;

   // pad three zero bits below the word so a short tail lands MSB-aligned
   assign word_ext  = {word, {FIELD_BITS{1'b0}}};
   assign bits_wide = {{(REM_BITS-BPC_BITS){1'b0}}, bits};
   assign shift_amt = rem_in + REM_BITS'(FIELD_BITS) - bits_wide;
   assign shifted   = word_ext >> shift_amt;
   assign field     = shifted[FIELD_BITS-1:0] & low_mask_f(bits);

   always_comb begin
      if (rem_in == '0) begin
         chan_out = chan_in;
         rem_out  = '0;
      end else begin
         chan_out = (chan_in & clear_mask_f(bits))
                  | {{(CHAN_BITS-FIELD_BITS){1'b0}}, field};
         rem_out  = (rem_in > bits_wide) ? rem_in - bits_wide : '0;
      end
   end

endmodule

@@ src/lsb_pixel_stego_embedder_unit.sv @@
// Top level of the LSB pixel steganography embedder.
// Depends on lpse_pkg and lpse_channel_insert.
//
// Pixels arrive in raster order, one beat per pixel, and leave in the same
// order with message bits hidden in the low bits of red, green and blue.
// The first 32-bit word is the message length, then one word per character
// (char_code zero-extended), MSB first, R then G then B, bits_per_channel
// bits per channel (0 acts as 3). A word that ends inside a pixel pads its
// last field with zero low bits and leaves the following channels untouched;
// the next word starts on the next pixel. Length-word pixels keep alpha,
// character pixels get alpha 0, and once message_length characters are in,
// pixels pass unchanged with message_done set. char_taken marks the pixel
// that finished a character: hold char_code until that beat is seen. The
// block takes one pixel per cycle while rsp_stall does not hold it back; a
// pixel passes an input register then a result register, with the bit pointer
// update (three chained channel inserts of a 35-bit shift each) in between.
// Write the csr registers only while no pixel is in flight.
module lsb_pixel_stego_embedder_unit (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write,
   input  logic [lpse_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lpse_pkg::CSR_DATA_BITS-1:0]  csr_data,
   // pixel input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lpse_pkg::CHAN_BITS-1:0]      req_red_in,
   input  logic [lpse_pkg::CHAN_BITS-1:0]      req_green_in,
   input  logic [lpse_pkg::CHAN_BITS-1:0]      req_blue_in,
   input  logic [lpse_pkg::CHAN_BITS-1:0]      req_alpha_in,
   input  logic [lpse_pkg::CHAR_BITS-1:0]      req_char_code,
   // pixel output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lpse_pkg::CHAN_BITS-1:0]      rsp_red_out,
   output logic [lpse_pkg::CHAN_BITS-1:0]      rsp_green_out,
   output logic [lpse_pkg::CHAN_BITS-1:0]      rsp_blue_out,
   output logic [lpse_pkg::CHAN_BITS-1:0]      rsp_alpha_out,
   output logic                                rsp_char_taken,
   output logic                                rsp_message_done
);
   import lpse_pkg::*;

   // configuration registers
   logic [BPC_BITS-1:0]     bits_per_channel_ff;
   logic [MSG_LEN_BITS-1:0] message_length_ff;

   // embedding state
   logic [REM_BITS-1:0]     bits_remaining_ff, bits_remaining_in;
   logic [COUNT_BITS-1:0]   word_counter_ff, word_counter_in;

   // input stage
   logic                    in_valid_ff;
   logic [CHAN_BITS-1:0]    in_red_ff, in_green_ff, in_blue_ff, in_alpha_ff;
   logic [CHAR_BITS-1:0]    in_char_ff;

   // result stage
   logic                    out_valid_ff;
   logic [CHAN_BITS-1:0]    out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;
   logic                    out_taken_ff, out_done_ff;

   logic                    out_free;
   logic                    advance;
   logic                    in_load;

   logic                    msg_done;
   logic                    header;
   logic [BPC_BITS-1:0]     eff_bits;
   logic [WORD_BITS-1:0]    word;
   logic [REM_BITS-1:0]     rem_r, rem_g, rem_b;
   logic [CHAN_BITS-1:0]    red_emb, green_emb, blue_emb;
   logic                    word_done;

   logic [CHAN_BITS-1:0]    red_in, green_in, blue_in, alpha_in;
   logic                    taken_in, done_in;

   // ---------------------------------------------------------------- handshake
   // result register frees when empty or when its beat is taken
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign in_load   = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !advance;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_per_channel_ff <= BPC_RESET;
         message_length_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BITS_PER_CHANNEL: bits_per_channel_ff <= csr_data[BPC_BITS-1:0];
            CSR_MESSAGE_LENGTH:   message_length_ff   <= csr_data[MSG_LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_red_ff   <= req_red_in;
         in_green_ff <= req_green_in;
         in_blue_ff  <= req_blue_in;
         in_alpha_ff <= req_alpha_in;
         in_char_ff  <= req_char_code;
      end
   end

   // ---------------------------------------------------------------- embed
   // message is done once the word index passes the character count
   assign msg_done = word_counter_ff > {1'b0, message_length_ff};
   assign header   = (word_counter_ff == '0);
   assign eff_bits = (bits_per_channel_ff == '0) ? 2'd3 : bits_per_channel_ff;
   assign word     = header ? {{(WORD_BITS-MSG_LEN_BITS){1'b0}}, message_length_ff}
                            : {{(WORD_BITS-CHAR_BITS){1'b0}}, in_char_ff};

   lpse_channel_insert u_red (
      .chan_in  (in_red_ff),
      .word     (word),
      .rem_in   (bits_remaining_ff),
      .bits     (eff_bits),
      .chan_out (red_emb),
      .rem_out  (rem_r)
   );

   lpse_channel_insert u_green (
      .chan_in  (in_green_ff),
      .word     (word),
      .rem_in   (rem_r),
      .bits     (eff_bits),
      .chan_out (green_emb),
      .rem_out  (rem_g)
   );

   lpse_channel_insert u_blue (
      .chan_in  (in_blue_ff),
      .word     (word),
      .rem_in   (rem_g),
      .bits     (eff_bits),
      .chan_out (blue_emb),
      .rem_out  (rem_b)
   );

   assign word_done = (rem_b == '0);

   // result beat for the pixel in the input stage
   always_comb begin
      if (msg_done) begin
         red_in   = in_red_ff;
         green_in = in_green_ff;
         blue_in  = in_blue_ff;
         alpha_in = in_alpha_ff;
         taken_in = 1'b0;
         done_in  = 1'b1;
      end else begin
         red_in   = red_emb;
         green_in = green_emb;
         blue_in  = blue_emb;
         alpha_in = header ? in_alpha_ff : '0;
         taken_in = word_done && !header;
         done_in  = 1'b0;
      end
   end

   // bit pointer: advance to the next word on completion, else keep the tail
   always_comb begin
      bits_remaining_in = bits_remaining_ff;
      word_counter_in   = word_counter_ff;
      if (!msg_done) begin
         if (word_done) begin
            bits_remaining_in = REM_FULL;
            word_counter_in   = word_counter_ff + 1'b1;
         end else begin
            bits_remaining_in = rem_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_remaining_ff <= REM_FULL;
         word_counter_ff   <= '0;
      end else if (advance) begin
         bits_remaining_ff <= bits_remaining_in;
         word_counter_ff   <= word_counter_in;
      end
   end

   // ---------------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_red_ff   <= red_in;
         out_green_ff <= green_in;
         out_blue_ff  <= blue_in;
         out_alpha_ff <= alpha_in;
         out_taken_ff <= taken_in;
         out_done_ff  <= done_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_red_out      = out_red_ff;
   assign rsp_green_out    = out_green_ff;
   assign rsp_blue_out     = out_blue_ff;
   assign rsp_alpha_out    = out_alpha_ff;
   assign rsp_char_taken   = out_taken_ff;
   assign rsp_message_done = out_done_ff;

`ifndef SYNTHESIS
   // the bit pointer always names a live position inside a 32-bit word
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      bits_remaining_ff != '0 && bits_remaining_ff <= REM_FULL)
      else $error("bits_remaining out of range");

   // a finished word moves the counter by exactly one and restarts the word
   a_word_step: assert property (@(posedge clock) disable iff (reset)
      advance && !msg_done && word_done |=>
         word_counter_ff == $past(word_counter_ff) + 1'b1
         && bits_remaining_ff == REM_FULL)
      else $error("word counter did not step on word completion");

   // a pass-through beat never claims a character
   a_taken_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_char_taken && rsp_message_done))
      else $error("char_taken on a pass-through pixel");

   // stall only with a held pixel in the input stage
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without back-pressure");
`endif

endmodule
